[src/assert_macros.svh]
// Assertion helpers for the RTL. Each use names a label, a condition
// (or an antecedent and a consequent) and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LLHB_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define LLHB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define LLHB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/llhb_pkg.sv]
package llhb_pkg;

   localparam int MAX_SYMBOLS = 512;
   localparam int NODES       = 2 * MAX_SYMBOLS - 1;
   localparam int MAXLEN      = 16;
   localparam int SYM_W       = $clog2(MAX_SYMBOLS);
   localparam int NODE_W      = $clog2(NODES);
   localparam int CNT_W       = 16;
   localparam int LEN_W       = 5;

   localparam logic [NODE_W-1:0] NUM_SYMBOLS_RESET = NODE_W'(510);

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_READ   = 1'b1;
   localparam logic RES_SUMMARY = 1'b0;
   localparam logic RES_CODE    = 1'b1;

   typedef struct packed {
      logic              take;
      logic              kind;
      logic [SYM_W-1:0]  sym;
      logic [CNT_W-1:0]  freq;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [NODE_W-1:0] root;
      logic              tree;
      logic [CNT_W-1:0]  total;
      logic [LEN_W-1:0]  len;
      logic [CNT_W-1:0]  code;
   } res_type;

   function automatic logic [CNT_W-1:0] code_weight(input logic [LEN_W-1:0] len);
      return 16'h8000 >> (len - LEN_W'(1));
   endfunction

endpackage

[src/llhb_ram.sv]
module llhb_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[src/llhb_build.sv]
`include "assert_macros.svh"

module llhb_build (
   input  logic                          clock,
   input  logic                          reset,
   input  llhb_pkg::cmd_type             cmd,
   input  logic [llhb_pkg::NODE_W-1:0]   nsym,
   input  logic                          out_free,
   output logic                          busy,
   output llhb_pkg::res_type             res
);

   import llhb_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RD      = 5'd1;
   localparam logic [4:0] S_SCAN    = 5'd2;
   localparam logic [4:0] S_HEAPIFY = 5'd3;
   localparam logic [4:0] S_SD_K0   = 5'd4;
   localparam logic [4:0] S_SD_K1   = 5'd5;
   localparam logic [4:0] S_SD_K2   = 5'd6;
   localparam logic [4:0] S_SD_L0   = 5'd7;
   localparam logic [4:0] S_SD_L1   = 5'd8;
   localparam logic [4:0] S_SD_L2   = 5'd9;
   localparam logic [4:0] S_SD_L3   = 5'd10;
   localparam logic [4:0] S_EA0     = 5'd11;
   localparam logic [4:0] S_EA1     = 5'd12;
   localparam logic [4:0] S_EA2     = 5'd13;
   localparam logic [4:0] S_EA3     = 5'd14;
   localparam logic [4:0] S_EB0     = 5'd15;
   localparam logic [4:0] S_EB1     = 5'd16;
   localparam logic [4:0] S_EB2     = 5'd17;
   localparam logic [4:0] S_W_NODE  = 5'd18;
   localparam logic [4:0] S_W_POP   = 5'd19;
   localparam logic [4:0] S_W_CH    = 5'd20;
   localparam logic [4:0] S_KRAFT   = 5'd21;
   localparam logic [4:0] S_FIX     = 5'd22;
   localparam logic [4:0] S_ASG     = 5'd23;
   localparam logic [4:0] S_START   = 5'd24;
   localparam logic [4:0] S_CODE    = 5'd25;
   localparam logic [4:0] S_DONE    = 5'd26;

   localparam logic [1:0] RET_HEAP = 2'd0;
   localparam logic [1:0] RET_EA   = 2'd1;
   localparam logic [1:0] RET_EB   = 2'd2;

   localparam int HEAP_DEPTH = MAX_SYMBOLS + 1;
   localparam int HEAP_W     = $clog2(HEAP_DEPTH);
   localparam int STK_W      = NODE_W + LEN_W;

   localparam logic [NODE_W-1:0] N_MAX     = NODE_W'(MAX_SYMBOLS);
   localparam logic [NODE_W-1:0] NODE_END  = NODE_W'(NODES);
   localparam logic [NODE_W-1:0] NODE_TOP  = NODE_W'(NODES - 1);
   localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAXLEN);

   // Memory ports.
   logic                cnt_we, cnt_re;
   logic [NODE_W-1:0]   cnt_wa, cnt_ra;
   logic [CNT_W-1:0]    cnt_wd, cnt_rd;
   logic                heap_we, heap_re;
   logic [HEAP_W-1:0]   heap_wa, heap_ra;
   logic [NODE_W-1:0]   heap_wd, heap_rd;
   logic                lc_we, lc_re;
   logic [NODE_W-1:0]   lc_wd, lc_rd;
   logic [NODE_W-1:0]   rc_rd;
   logic [NODE_W-1:0]   ch_wa, ch_ra;
   logic                leaf_we, leaf_re;
   logic [SYM_W-1:0]    leaf_wa, leaf_ra, leaf_wd, leaf_rd;
   logic                stk_we, stk_re;
   logic [SYM_W-1:0]    stk_wa, stk_ra;
   logic [STK_W-1:0]    stk_wd, stk_rd;
   logic                slen_we, slen_re;
   logic [SYM_W-1:0]    slen_wa, slen_ra;
   logic [LEN_W-1:0]    slen_wd, slen_rd;
   logic                scode_we, scode_re;
   logic [SYM_W-1:0]    scode_wa, scode_ra;
   logic [CNT_W-1:0]    scode_wd, scode_rd;

   // Sequencer registers.
   logic [4:0]          st_ff, st_in;
   logic [1:0]          ret_ff, ret_in;
   logic [NODE_W-1:0]   n_ff, n_in;
   logic [NODE_W-1:0]   i_ff, i_in;
   logic                sv_ff, sv_in;
   logic [SYM_W-1:0]    sidx_ff, sidx_in;
   logic [HEAP_W-1:0]   hsize_ff, hsize_in;
   logic [NODE_W-1:0]   sole_ff, sole_in;
   logic                tree_ff, tree_in;
   logic [HEAP_W-1:0]   pos_ff, pos_in;
   logic [HEAP_W-1:0]   c_ff, c_in;
   logic [NODE_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]    kc_ff, kc_in;
   logic [NODE_W-1:0]   hc_ff, hc_in;
   logic [CNT_W-1:0]    hcc_ff, hcc_in;
   logic [NODE_W-1:0]   a_ff, a_in;
   logic [CNT_W-1:0]    ac_ff, ac_in;
   logic [NODE_W-1:0]   b_ff, b_in;
   logic [NODE_W-1:0]   avail_ff, avail_in;
   logic [NODE_W-1:0]   nleaves_ff, nleaves_in;
   logic [NODE_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    rootc_ff, rootc_in;
   logic [SYM_W-1:0]    sp_ff, sp_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [LEN_W-1:0]    cd_ff, cd_in;
   logic [CNT_W-1:0]    hist_ff [0:MAXLEN];
   logic [CNT_W-1:0]    hist_in [0:MAXLEN];
   logic [CNT_W-1:0]    cum_ff, cum_in;
   logic [LEN_W-1:0]    li_ff, li_in;
   logic [CNT_W-1:0]    kl_ff, kl_in;
   logic [NODE_W-1:0]   lpos_ff, lpos_in;
   logic                av_ff, av_in;
   logic [LEN_W-1:0]    al_ff, al_in;
   logic [CNT_W-1:0]    start_ff [0:MAXLEN];
   logic [CNT_W-1:0]    start_in [0:MAXLEN];
   logic                cv_ff, cv_in;
   logic [SYM_W-1:0]    cidx_ff, cidx_in;

   // Combinational helpers.
   logic [HEAP_W:0]     c_wide;
   logic                c_lt;
   logic                take_right;
   logic [NODE_W-1:0]   child;
   logic [CNT_W-1:0]    child_cnt;
   logic [HEAP_W-1:0]   child_pos;
   logic                sd_ret;
   logic                w_leaf;
   logic [LEN_W-1:0]    nd;
   logic [CNT_W-1:0]    term;
   logic [CNT_W-1:0]    cum_next;
   logic [LEN_W-1:0]    fix_sel;
   logic                fix_hit;
   logic [NODE_W-1:0]   k_new;
   logic [CNT_W-1:0]    sum;

   llhb_ram #(.DEPTH(NODES), .WIDTH(CNT_W)) u_cnt (
      .clock(clock), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
      .re(cnt_re), .raddr(cnt_ra), .rdata(cnt_rd)
   );
   llhb_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(NODE_W)) u_heap (
      .clock(clock), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
      .re(heap_re), .raddr(heap_ra), .rdata(heap_rd)
   );
   llhb_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_left (
      .clock(clock), .we(lc_we), .waddr(ch_wa), .wdata(lc_wd),
      .re(lc_re), .raddr(ch_ra), .rdata(lc_rd)
   );
   llhb_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_right (
      .clock(clock), .we(lc_we), .waddr(ch_wa), .wdata(b_ff),
      .re(lc_re), .raddr(ch_ra), .rdata(rc_rd)
   );
   llhb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(SYM_W)) u_leaf (
      .clock(clock), .we(leaf_we), .waddr(leaf_wa), .wdata(leaf_wd),
      .re(leaf_re), .raddr(leaf_ra), .rdata(leaf_rd)
   );
   llhb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(STK_W)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
   );
   llhb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(LEN_W)) u_slen (
      .clock(clock), .we(slen_we), .waddr(slen_wa), .wdata(slen_wd),
      .re(slen_re), .raddr(slen_ra), .rdata(slen_rd)
   );
   llhb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(CNT_W)) u_scode (
      .clock(clock), .we(scode_we), .waddr(scode_wa), .wdata(scode_wd),
      .re(scode_re), .raddr(scode_ra), .rdata(scode_rd)
   );

   assign busy = (st_ff != S_IDLE);

   always_comb begin
      c_wide     = {pos_ff, 1'b0};
      c_lt       = (c_ff < hsize_ff);
      take_right = c_lt && (hcc_ff > cnt_rd);
      child      = take_right ? heap_rd : hc_ff;
      child_cnt  = take_right ? cnt_rd : hcc_ff;
      child_pos  = take_right ? (c_ff + HEAP_W'(1)) : c_ff;
      w_leaf     = (cur_ff < n_ff) || (cur_ff >= NODE_END);
      nd         = (cd_ff < LEN_MAX) ? (cd_ff + LEN_W'(1)) : LEN_MAX;
      term       = hist_ff[li_ff] << (LEN_MAX - li_ff);
      cum_next   = cum_ff + term;
      k_new      = (avail_ff >= NODE_END) ? NODE_TOP : avail_ff;
      sum        = ac_ff + cnt_rd;
      fix_sel    = '0;
      fix_hit    = 1'b0;
      for (int j = 1; j < MAXLEN; j++) begin
         if (hist_ff[j] != '0) begin
            fix_sel = LEN_W'(j);
            fix_hit = 1'b1;
         end
      end
   end

   always_comb begin
      st_in      = st_ff;
      ret_in     = ret_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      sv_in      = sv_ff;
      sidx_in    = sidx_ff;
      hsize_in   = hsize_ff;
      sole_in    = sole_ff;
      tree_in    = tree_ff;
      pos_in     = pos_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      kc_in      = kc_ff;
      hc_in      = hc_ff;
      hcc_in     = hcc_ff;
      a_in       = a_ff;
      ac_in      = ac_ff;
      b_in       = b_ff;
      avail_in   = avail_ff;
      nleaves_in = nleaves_ff;
      root_in    = root_ff;
      rootc_in   = rootc_ff;
      sp_in      = sp_ff;
      cur_in     = cur_ff;
      cd_in      = cd_ff;
      hist_in    = hist_ff;
      cum_in     = cum_ff;
      li_in      = li_ff;
      kl_in      = kl_ff;
      lpos_in    = lpos_ff;
      av_in      = av_ff;
      al_in      = al_ff;
      start_in   = start_ff;
      cv_in      = cv_ff;
      cidx_in    = cidx_ff;
      sd_ret     = 1'b0;

      cnt_we   = 1'b0; cnt_wa  = '0; cnt_wd  = '0; cnt_re  = 1'b0; cnt_ra  = '0;
      heap_we  = 1'b0; heap_wa = '0; heap_wd = '0; heap_re = 1'b0; heap_ra = '0;
      lc_we    = 1'b0; ch_wa   = '0; lc_wd   = '0; lc_re   = 1'b0; ch_ra   = '0;
      leaf_we  = 1'b0; leaf_wa = '0; leaf_wd = '0; leaf_re = 1'b0; leaf_ra = '0;
      stk_we   = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_re  = 1'b0; stk_ra  = '0;
      slen_we  = 1'b0; slen_wa = '0; slen_wd = '0; slen_re = 1'b0; slen_ra = '0;
      scode_we = 1'b0; scode_wa = '0; scode_wd = '0; scode_re = 1'b0; scode_ra = '0;

      res = '0;

      case (st_ff)
         S_IDLE: begin
            if (cmd.take) begin
               if (cmd.kind == KIND_LOAD) begin
                  cnt_we = 1'b1;
                  cnt_wa = NODE_W'(cmd.sym);
                  cnt_wd = cmd.freq;
                  if (cmd.last) begin
                     n_in     = (nsym > N_MAX) ? N_MAX : nsym;
                     i_in     = '0;
                     sv_in    = 1'b0;
                     hsize_in = '0;
                     sole_in  = '0;
                     st_in    = S_SCAN;
                  end
               end else begin
                  slen_re  = 1'b1;
                  slen_ra  = cmd.sym;
                  scode_re = 1'b1;
                  scode_ra = cmd.sym;
                  st_in    = S_RD;
               end
            end
         end
         S_RD: begin
            if (out_free) begin
               res.valid = 1'b1;
               res.kind  = RES_CODE;
               res.len   = slen_rd;
               res.code  = (slen_rd != '0) ? scode_rd : '0;
               st_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!i_ff[NODE_W-1]) begin
               slen_we = 1'b1;
               slen_wa = i_ff[SYM_W-1:0];
               slen_wd = '0;
               cnt_re  = 1'b1;
               cnt_ra  = i_ff;
               sv_in   = 1'b1;
               sidx_in = i_ff[SYM_W-1:0];
               i_in    = i_ff + NODE_W'(1);
            end else begin
               sv_in = 1'b0;
            end
            if (sv_ff && (NODE_W'(sidx_ff) < n_ff) && (cnt_rd != '0)) begin
               heap_we  = 1'b1;
               heap_wa  = hsize_ff + HEAP_W'(1);
               heap_wd  = NODE_W'(sidx_ff);
               hsize_in = hsize_ff + HEAP_W'(1);
               if (hsize_ff == '0) begin
                  sole_in = NODE_W'(sidx_ff);
               end
            end
            if (i_ff[NODE_W-1] && !sv_ff) begin
               if (hsize_ff < HEAP_W'(2)) begin
                  tree_in = 1'b0;
                  st_in   = S_DONE;
               end else begin
                  i_in       = NODE_W'(hsize_ff >> 1);
                  avail_in   = n_ff;
                  nleaves_in = '0;
                  st_in      = S_HEAPIFY;
               end
            end
         end
         S_HEAPIFY: begin
            if (i_ff == '0) begin
               st_in = S_EA0;
            end else begin
               pos_in = HEAP_W'(i_ff);
               ret_in = RET_HEAP;
               st_in  = S_SD_K0;
            end
         end
         S_SD_K0: begin
            heap_re = 1'b1;
            heap_ra = pos_ff;
            st_in   = S_SD_K1;
         end
         S_SD_K1: begin
            k_in   = heap_rd;
            cnt_re = 1'b1;
            cnt_ra = heap_rd;
            st_in  = S_SD_K2;
         end
         S_SD_K2: begin
            kc_in = cnt_rd;
            st_in = S_SD_L0;
         end
         S_SD_L0: begin
            if (c_wide > {1'b0, hsize_ff}) begin
               heap_we = 1'b1;
               heap_wa = pos_ff;
               heap_wd = k_ff;
               sd_ret  = 1'b1;
            end else begin
               heap_re = 1'b1;
               heap_ra = c_wide[HEAP_W-1:0];
               c_in    = c_wide[HEAP_W-1:0];
               st_in   = S_SD_L1;
            end
         end
         S_SD_L1: begin
            hc_in  = heap_rd;
            cnt_re = 1'b1;
            cnt_ra = heap_rd;
            if (c_lt) begin
               heap_re = 1'b1;
               heap_ra = c_ff + HEAP_W'(1);
            end
            st_in = S_SD_L2;
         end
         S_SD_L2: begin
            hcc_in = cnt_rd;
            if (c_lt) begin
               cnt_re = 1'b1;
               cnt_ra = heap_rd;
            end
            st_in = S_SD_L3;
         end
         S_SD_L3: begin
            heap_we = 1'b1;
            heap_wa = pos_ff;
            if (kc_ff <= child_cnt) begin
               heap_wd = k_ff;
               sd_ret  = 1'b1;
            end else begin
               heap_wd = child;
               pos_in  = child_pos;
               st_in   = S_SD_L0;
            end
         end
         S_EA0: begin
            heap_re = 1'b1;
            heap_ra = HEAP_W'(1);
            st_in   = S_EA1;
         end
         S_EA1: begin
            a_in = heap_rd;
            if (heap_rd < n_ff) begin
               leaf_we    = 1'b1;
               leaf_wa    = nleaves_ff[SYM_W-1:0];
               leaf_wd    = heap_rd[SYM_W-1:0];
               nleaves_in = nleaves_ff + NODE_W'(1);
            end
            cnt_re  = 1'b1;
            cnt_ra  = heap_rd;
            heap_re = 1'b1;
            heap_ra = hsize_ff;
            st_in   = S_EA2;
         end
         S_EA2: begin
            ac_in    = cnt_rd;
            k_in     = heap_rd;
            cnt_re   = 1'b1;
            cnt_ra   = heap_rd;
            hsize_in = hsize_ff - HEAP_W'(1);
            st_in    = S_EA3;
         end
         S_EA3: begin
            kc_in  = cnt_rd;
            pos_in = HEAP_W'(1);
            ret_in = RET_EA;
            st_in  = S_SD_L0;
         end
         S_EB0: begin
            heap_re = 1'b1;
            heap_ra = HEAP_W'(1);
            st_in   = S_EB1;
         end
         S_EB1: begin
            b_in = heap_rd;
            if (heap_rd < n_ff) begin
               leaf_we    = 1'b1;
               leaf_wa    = nleaves_ff[SYM_W-1:0];
               leaf_wd    = heap_rd[SYM_W-1:0];
               nleaves_in = nleaves_ff + NODE_W'(1);
            end
            cnt_re = 1'b1;
            cnt_ra = heap_rd;
            st_in  = S_EB2;
         end
         S_EB2: begin
            cnt_we   = 1'b1;
            cnt_wa   = k_new;
            cnt_wd   = sum;
            lc_we    = 1'b1;
            ch_wa    = k_new;
            lc_wd    = a_ff;
            avail_in = avail_ff + NODE_W'(1);
            k_in     = k_new;
            kc_in    = sum;
            root_in  = k_new;
            rootc_in = sum;
            pos_in   = HEAP_W'(1);
            ret_in   = RET_EB;
            st_in    = S_SD_L0;
         end
         S_W_NODE: begin
            if (w_leaf) begin
               hist_in[cd_ff] = hist_ff[cd_ff] + CNT_W'(1);
               if (sp_ff == '0) begin
                  li_in  = LEN_MAX;
                  cum_in = '0;
                  st_in  = S_KRAFT;
               end else begin
                  stk_re = 1'b1;
                  stk_ra = sp_ff - SYM_W'(1);
                  sp_in  = sp_ff - SYM_W'(1);
                  st_in  = S_W_POP;
               end
            end else begin
               lc_re = 1'b1;
               ch_ra = cur_ff;
               st_in = S_W_CH;
            end
         end
         S_W_POP: begin
            cur_in = stk_rd[STK_W-1:LEN_W];
            cd_in  = stk_rd[LEN_W-1:0];
            st_in  = S_W_NODE;
         end
         S_W_CH: begin
            stk_we = 1'b1;
            stk_wa = sp_ff;
            stk_wd = {rc_rd, nd};
            sp_in  = sp_ff + SYM_W'(1);
            cur_in = lc_rd;
            cd_in  = nd;
            st_in  = S_W_NODE;
         end
         S_KRAFT: begin
            cum_in = cum_next;
            li_in  = li_ff - LEN_W'(1);
            if (li_ff == LEN_W'(1)) begin
               hist_in[MAXLEN] = hist_ff[MAXLEN] - cum_next;
               st_in           = S_FIX;
            end
         end
         S_FIX: begin
            if (cum_ff == '0) begin
               li_in   = LEN_MAX;
               kl_in   = hist_ff[MAXLEN];
               lpos_in = '0;
               av_in   = 1'b0;
               st_in   = S_ASG;
            end else begin
               cum_in = cum_ff - CNT_W'(1);
               if (fix_hit) begin
                  hist_in[fix_sel] = hist_ff[fix_sel] - CNT_W'(1);
                  hist_in[fix_sel + LEN_W'(1)] =
                     hist_ff[fix_sel + LEN_W'(1)] + CNT_W'(2);
               end
            end
         end
         S_ASG: begin
            if (av_ff) begin
               slen_we = 1'b1;
               slen_wa = leaf_rd;
               slen_wd = al_ff;
            end
            if ((li_ff == '0) || (lpos_ff >= nleaves_ff)) begin
               av_in = 1'b0;
               if (!av_ff) begin
                  li_in  = LEN_W'(1);
                  cum_in = '0;
                  st_in  = S_START;
               end
            end else if (kl_ff == '0) begin
               li_in = li_ff - LEN_W'(1);
               kl_in = hist_ff[li_ff - LEN_W'(1)];
               av_in = 1'b0;
            end else begin
               leaf_re = 1'b1;
               leaf_ra = lpos_ff[SYM_W-1:0];
               lpos_in = lpos_ff + NODE_W'(1);
               kl_in   = kl_ff - CNT_W'(1);
               av_in   = 1'b1;
               al_in   = li_ff;
            end
         end
         S_START: begin
            start_in[li_ff] = cum_ff;
            cum_in          = cum_next;
            li_in           = li_ff + LEN_W'(1);
            if (li_ff == LEN_MAX) begin
               i_in  = '0;
               cv_in = 1'b0;
               st_in = S_CODE;
            end
         end
         S_CODE: begin
            if (i_ff < n_ff) begin
               slen_re = 1'b1;
               slen_ra = i_ff[SYM_W-1:0];
               cv_in   = 1'b1;
               cidx_in = i_ff[SYM_W-1:0];
               i_in    = i_ff + NODE_W'(1);
            end else begin
               cv_in = 1'b0;
            end
            if (cv_ff) begin
               scode_we = 1'b1;
               scode_wa = cidx_ff;
               if ((slen_rd == '0) || (slen_rd > LEN_MAX)) begin
                  scode_wd = '0;
               end else begin
                  scode_wd          = start_ff[slen_rd];
                  start_in[slen_rd] = start_ff[slen_rd] + code_weight(slen_rd);
               end
            end
            if (!(i_ff < n_ff) && !cv_ff) begin
               tree_in = 1'b1;
               st_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res.valid = 1'b1;
               res.kind  = RES_SUMMARY;
               res.root  = tree_ff ? root_ff : sole_ff;
               res.tree  = tree_ff;
               res.total = tree_ff ? rootc_ff : '0;
               st_in     = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (sd_ret) begin
         case (ret_ff)
            RET_HEAP: begin
               i_in  = i_ff - NODE_W'(1);
               st_in = S_HEAPIFY;
            end
            RET_EA: begin
               st_in = S_EB0;
            end
            RET_EB: begin
               if (hsize_ff > HEAP_W'(1)) begin
                  st_in = S_EA0;
               end else begin
                  cur_in = root_ff;
                  cd_in  = '0;
                  sp_in  = '0;
                  for (int j = 0; j <= MAXLEN; j++) begin
                     hist_in[j] = '0;
                  end
                  st_in = S_W_NODE;
               end
            end
            default: begin
               st_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         hsize_ff <= '0;
      end else begin
         st_ff    <= st_in;
         hsize_ff <= hsize_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      n_ff       <= n_in;
      i_ff       <= i_in;
      sv_ff      <= sv_in;
      sidx_ff    <= sidx_in;
      sole_ff    <= sole_in;
      tree_ff    <= tree_in;
      pos_ff     <= pos_in;
      c_ff       <= c_in;
      k_ff       <= k_in;
      kc_ff      <= kc_in;
      hc_ff      <= hc_in;
      hcc_ff     <= hcc_in;
      a_ff       <= a_in;
      ac_ff      <= ac_in;
      b_ff       <= b_in;
      avail_ff   <= avail_in;
      nleaves_ff <= nleaves_in;
      root_ff    <= root_in;
      rootc_ff   <= rootc_in;
      sp_ff      <= sp_in;
      cur_ff     <= cur_in;
      cd_ff      <= cd_in;
      hist_ff    <= hist_in;
      cum_ff     <= cum_in;
      li_ff      <= li_in;
      kl_ff      <= kl_in;
      lpos_ff    <= lpos_in;
      av_ff      <= av_in;
      al_ff      <= al_in;
      start_ff   <= start_in;
      cv_ff      <= cv_in;
      cidx_ff    <= cidx_in;
   end

   `LLHB_ASSERT_SAME(a_res_room, res.valid, out_free, "result produced while output is full")
   `LLHB_ASSERT_ALWAYS(a_heap_size, hsize_ff <= HEAP_W'(MAX_SYMBOLS), "heap size overflow")
   `LLHB_ASSERT_SAME(a_sift_pos, st_ff == S_SD_L0, pos_ff != '0, "sift at heap slot zero")
   `LLHB_ASSERT_NEXT(a_read_seq, cmd.take && cmd.kind == KIND_READ, st_ff == S_RD, "read not started")

endmodule

[src/length_limited_huffman_builder.sv]
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  kind, symbol_index, frequency, last
// rsp_       out        rsp_valid/rsp_stall  result_kind, root_node, is_tree,
//                                            total_count, code_length, code_word
// csr_       in         csr_write_enable     num_symbols (10 bits)
//
// A load that is not last leaves the block idle, ready for the next request. A read
// first reads the length and code tables, then loads the result register once the
// output is free. A build scans the table, fetches each key and sifts it down the heap
// level by level, walks the tree to find the code depths, removes the Kraft excess one
// unit at a time, and assigns lengths per leaf and codes per symbol; the single read
// port of the node and heap memories sets the pace. Reset is synchronous and clears
// only control state; the memories hold no reset value. req_stall is high during
// reads and builds, and while a finished result waits on rsp_stall.
module length_limited_huffman_builder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [llhb_pkg::SYM_W-1:0]    req_symbol_index,
   input  logic [llhb_pkg::CNT_W-1:0]    req_frequency,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic [llhb_pkg::NODE_W-1:0]   rsp_root_node,
   output logic                          rsp_is_tree,
   output logic [llhb_pkg::CNT_W-1:0]    rsp_total_count,
   output logic [llhb_pkg::LEN_W-1:0]    rsp_code_length,
   output logic [llhb_pkg::CNT_W-1:0]    rsp_code_word,
   input  logic                          csr_write_enable,
   input  logic [llhb_pkg::NODE_W-1:0]   csr_write_data
);

   import llhb_pkg::*;

   logic [NODE_W-1:0] nsym_ff, nsym_in;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           out_ff;
   cmd_type           cmd;
   res_type           res;
   logic              busy;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy || (rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd.take = req_valid && !req_stall;
      cmd.kind = req_kind;
      cmd.sym  = req_symbol_index;
      cmd.freq = req_frequency;
      cmd.last = req_last;
   end

   llhb_build u_build (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .nsym     (nsym_ff),
      .out_free (out_free),
      .busy     (busy),
      .res      (res)
   );

   always_comb begin
      nsym_in = csr_write_enable ? csr_write_data : nsym_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nsym_ff      <= NUM_SYMBOLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         nsym_ff      <= nsym_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_root_node   = out_ff.root;
   assign rsp_is_tree     = out_ff.tree;
   assign rsp_total_count = out_ff.total;
   assign rsp_code_length = out_ff.len;
   assign rsp_code_word   = out_ff.code;

endmodule
